FILE: design/dr_pkg.sv
// Shared types, register codes and the compact encoder for the difficulty retarget block.
// No dependencies; every other file in the design imports this package.
`default_nettype none
package dr_pkg;

  // Widest target the block supports and the width of a bit position in it.
  localparam int MaxBits = 256;
  localparam int LeadW   = 8;

  // Register indexes on the configuration port (byte address is 8 times the index).
  localparam logic [2:0] RegNoRetarget = 3'd0;
  localparam logic [2:0] RegTimespan   = 3'd1;
  localparam logic [2:0] RegInterval   = 3'd2;
  localparam logic [2:0] RegLimit0     = 3'd3;
  localparam logic [2:0] RegLimit1     = 3'd4;
  localparam logic [2:0] RegLimit2     = 3'd5;
  localparam logic [2:0] RegLimit3     = 3'd6;

  // Configuration values as the datapath sees them.
  typedef struct packed {
    logic        nr;        // return last_bits unchanged
    logic [31:0] tt;        // target timespan, zero taken as one
    logic [15:0] interval;  // adjustment interval
    logic [32:0] lo;        // 92 percent of tt, rounded down
    logic [32:0] hi;        // 116 percent of tt, rounded down
    logic [31:0] lim_bits;  // compact form of the limit
    logic        busy;      // derived values are being recomputed
  } cfg_t;

  // Item fields that ride along the datapath untouched.
  typedef struct packed {
    logic        nr;
    logic        early;
    logic [31:0] bits;
  } side_t;

  // Per-item state handed from one divider cell to the next.
  typedef struct packed {
    side_t             side;
    logic [31:0]       rem;      // partial remainder, always below the divisor
    logic              lead_ok;  // a one has been seen in the quotient
    logic [LeadW-1:0]  lead;     // position of the leading quotient one
    logic              gt;       // quotient is above the limit
    logic              lt;       // quotient is below the limit
  } cell_t;

  // One result item.
  typedef struct packed {
    logic [31:0] bits;
    logic        hit;
  } res_t;

  // Compact encoding of a value whose leading one position is already known.
  function automatic logic [31:0] enc_compact(logic [MaxBits-1:0] v, logic ok,
                                              logic [LeadW-1:0] lead);
    logic [8:0]          nbits;
    logic [5:0]          size;
    logic [MaxBits+23:0] w;
    logic [23:0]         c;
    logic [7:0]          sz8;
    nbits = ok ? ({1'b0, lead} + 9'd1) : 9'd0;
    size  = 6'((nbits + 9'd7) >> 3);
    w     = {v, 24'b0};
    // The three bytes just below the top byte boundary, zero filled from below.
    c     = w[{size, 3'b0} +: 24];
    sz8   = {2'b0, size};
    if (c[23]) begin
      c   = c >> 8;
      sz8 = sz8 + 8'd1;
    end
    return {sz8, c};
  endfunction

endpackage
`default_nettype wire

FILE: design/difficulty_retarget.sv
// Path from an accepted item to its result: six front stages, one divider cell per target
// bit, then the output buffer. One item per cycle unless the full output buffer is not drained
// or the derived values are being recomputed. After reset and after every configuration
// write the clamp bounds and the compact limit are recomputed with in_ready_o low; the item
// path holds no other state. Output is a two-entry buffer, so inputs flow while a result waits.
// Top level of the retarget block; depends on dr_pkg, dr_cfg, dr_front and dr_cell.
`default_nettype none
module difficulty_retarget import dr_pkg::*; #(
  parameter int TB = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] last_bits_i,
  input  wire logic [30:0] last_height_i,
  input  wire logic [31:0] last_median_time_i,
  input  wire logic [31:0] first_median_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] next_bits_o,
  output logic             limit_hit_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  cfg_t          cfg;
  logic [TB-1:0] lim;
  logic          adv;
  logic          acc;
  logic          cvld [TB+1];
  cell_t         cdat [TB+1];
  logic [TB-1:0] cw   [TB+1];
  res_t          res;
  res_t          ent0_q, ent1_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  dr_cfg #(.TB(TB)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg), .lim_o(lim)
  );

  // The whole datapath moves unless the output buffer is full and not drained.
  assign adv        = (cnt_q != 2'd2) || out_ready_i;
  assign in_ready_o = adv && !cfg.busy;
  assign acc        = in_valid_i && in_ready_o;

  dr_front #(.TB(TB)) u_front (
    .clk_i, .rst_ni, .adv_i(adv), .acc_i(acc),
    .last_bits_i, .last_height_i, .last_median_time_i, .first_median_time_i,
    .cfg_i(cfg), .vld_o(cvld[0]), .dat_o(cdat[0]), .val_o(cw[0])
  );

  // Divider chain, quotient bits from the most significant down.
  for (genvar k = 0; k < TB; k++) begin : g_cell
    dr_cell #(.TB(TB), .POS(TB - 1 - k)) u_cell (
      .clk_i, .rst_ni, .adv_i(adv), .div_i(cfg.tt), .lim_bit_i(lim[TB-1-k]),
      .vld_i(cvld[k]), .dat_i(cdat[k]), .w_i(cw[k]),
      .vld_o(cvld[k+1]), .dat_o(cdat[k+1]), .w_o(cw[k+1])
    );
  end

  // Result selection and encoding.
  always_comb begin
    if (cdat[TB].side.nr) begin
      res.bits = cdat[TB].side.bits;
      res.hit  = 1'b0;
    end else if (cdat[TB].side.early) begin
      res.bits = cfg.lim_bits;
      res.hit  = 1'b0;
    end else if (cdat[TB].gt) begin
      res.bits = cfg.lim_bits;
      res.hit  = 1'b1;
    end else begin
      res.bits = enc_compact(MaxBits'(cw[TB]), cdat[TB].lead_ok, cdat[TB].lead);
      res.hit  = 1'b0;
    end
  end

  // Two-entry output buffer.
  assign push = adv && cvld[TB];
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && cnt_q == 2'd1) begin
        ent0_q <= res;
      end else begin
        ent0_q <= ent1_q;
      end
      if (push && cnt_q == 2'd2) begin
        ent1_q <= res;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        ent0_q <= res;
      end else begin
        ent1_q <= res;
      end
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign next_bits_o = ent0_q.bits;
  assign limit_hit_o = ent0_q.hit;

  // Checks.
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.busy |-> !in_ready_o) else $error("item taken while derived values recompute");

  a_hit_is_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && limit_hit_o) |-> (next_bits_o == cfg.lim_bits))
    else $error("capped result differs from compact limit");

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer overfilled");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !out_ready_i) |-> !adv) else $error("datapath moved into full buffer");

endmodule
`default_nettype wire

FILE: design/dr_cfg.sv
// Configuration registers, APB-style access and the values derived from them.
// Depends on dr_pkg for register codes, cfg_t and the compact encoder.
`default_nettype none
module dr_cfg import dr_pkg::*; #(
  parameter int TB = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [5:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic      [63:0]   prdata,
  output logic               pready,
  output cfg_t               cfg_o,
  output logic      [TB-1:0] lim_o
);

  localparam int IW = $clog2(TB);
  // Reciprocal of 25 scaled by 2^37, rounded up; exact for every 32-bit dividend.
  localparam logic [32:0] Recip25 = 33'd5497558139;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StStart = 4'b0010,
    StRun   = 4'b0100,
    StFin   = 4'b1000
  } st_e;

  st_e                st_q;
  logic [IW-1:0]      cnt_q;
  logic               nr_q;
  logic [31:0]        tt_q;
  logic [15:0]        ai_q;
  logic [63:0]        lw0_q, lw1_q, lw2_q, lw3_q;
  logic [64:0]        prod_q;
  logic [27:0]        q25_q;
  logic [4:0]         r25_q;
  logic               found_q;
  logic [LeadW-1:0]   lead_q;
  logic [32:0]        lo_q, hi_q;
  logic [31:0]        lim_bits_q;

  logic [2:0]         idx;
  logic               wr;
  logic [31:0]        tt_eff;
  logic [255:0]       lim_full;
  logic [TB-1:0]      lim_tb;
  logic [27:0]        q25;
  logic [31:0]        r25;
  logic [4:0]         lo_frac, hi_frac;
  logic [IW-1:0]      bit_idx;

  assign idx      = paddr[5:3];
  assign wr       = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign tt_eff   = (tt_q == 32'd0) ? 32'd1 : tt_q;
  assign lim_full = {lw3_q, lw2_q, lw1_q, lw0_q};
  assign lim_tb   = lim_full[TB-1:0];
  assign lim_o    = lim_tb;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q  <= 1'b0;
      tt_q  <= 32'd1209600;
      ai_q  <= 16'd2016;
      lw0_q <= '1;
      lw1_q <= '1;
      lw2_q <= '1;
      lw3_q <= 64'h0000_0000_FFFF_FFFF;
    end else if (wr) begin
      unique case (idx)
        RegNoRetarget: nr_q  <= pwdata[0];
        RegTimespan:   tt_q  <= pwdata[31:0];
        RegInterval:   ai_q  <= pwdata[15:0];
        RegLimit0:     lw0_q <= pwdata;
        RegLimit1:     lw1_q <= pwdata;
        RegLimit2:     lw2_q <= pwdata;
        RegLimit3:     lw3_q <= pwdata;
        default:       ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (idx)
      RegNoRetarget: prdata = {63'b0, nr_q};
      RegTimespan:   prdata = {32'b0, tt_q};
      RegInterval:   prdata = {48'b0, ai_q};
      RegLimit0:     prdata = lw0_q;
      RegLimit1:     prdata = lw1_q;
      RegLimit2:     prdata = lw2_q;
      RegLimit3:     prdata = lw3_q;
      default:       prdata = 64'b0;
    endcase
  end

  // Split the timespan as 25 q + r; 92 and 116 percent are then 23 q and 29 q
  // plus the rounded-down share of r.
  assign q25     = prod_q[64:37];
  assign r25     = tt_eff - ({4'b0, q25} * 32'd25);
  assign bit_idx = IW'(TB - 1) - cnt_q;

  always_comb begin
    priority if (r25_q == 5'd0) begin
      lo_frac = 5'd0;
    end else if (r25_q <= 5'd12) begin
      lo_frac = r25_q - 5'd1;
    end else begin
      lo_frac = r25_q - 5'd2;
    end
  end

  always_comb begin
    priority if (r25_q <= 5'd6) begin
      hi_frac = r25_q;
    end else if (r25_q <= 5'd12) begin
      hi_frac = r25_q + 5'd1;
    end else if (r25_q <= 5'd18) begin
      hi_frac = r25_q + 5'd2;
    end else begin
      hi_frac = r25_q + 5'd3;
    end
  end

  // Sequencer: rerun the derived values after reset and after every write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StStart;
      cnt_q <= '0;
    end else if (wr) begin
      st_q  <= StStart;
      cnt_q <= '0;
    end else begin
      unique case (st_q)
        StIdle:  st_q <= StIdle;
        StStart: begin
          st_q  <= StRun;
          cnt_q <= '0;
        end
        StRun: begin
          if (cnt_q == IW'(TB - 1)) begin
            st_q <= StFin;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        StFin:   st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  // Datapath of the sequencer: reciprocal divide by 25 and a leading-one scan.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StStart: begin
        prod_q  <= 65'(tt_eff) * 65'(Recip25);
        found_q <= 1'b0;
        lead_q  <= '0;
      end
      StRun: begin
        q25_q <= q25;
        r25_q <= r25[4:0];
        if (lim_tb[bit_idx] && !found_q) begin
          found_q <= 1'b1;
          lead_q  <= LeadW'(bit_idx);
        end
      end
      StFin: begin
        lo_q       <= 33'(q25_q) * 33'd23 + 33'(lo_frac);
        hi_q       <= 33'(q25_q) * 33'd29 + 33'(hi_frac);
        lim_bits_q <= enc_compact(MaxBits'(lim_tb), found_q, lead_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg_o          = '0;
    cfg_o.nr       = nr_q;
    cfg_o.tt       = tt_eff;
    cfg_o.interval = ai_q;
    cfg_o.lo       = lo_q;
    cfg_o.hi       = hi_q;
    cfg_o.lim_bits = lim_bits_q;
    cfg_o.busy     = (st_q != StIdle);
  end

endmodule
`default_nettype wire

FILE: design/dr_front.sv
// Front pipeline: damped and clamped timespan, mantissa times timespan, shift into place.
// Depends on dr_pkg for cfg_t, side_t and cell_t.
`default_nettype none
module dr_front import dr_pkg::*; #(
  parameter int TB = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          acc_i,
  input  wire logic [31:0]   last_bits_i,
  input  wire logic [30:0]   last_height_i,
  input  wire logic [31:0]   last_median_time_i,
  input  wire logic [31:0]   first_median_time_i,
  input  wire cfg_t          cfg_i,
  output logic               vld_o,
  output cell_t              dat_o,
  output logic      [TB-1:0] val_o
);

  logic [5:0]         vld_q;
  logic [31:0]        bits0_q, lmt0_q, fmt0_q;
  logic [30:0]        ht0_q;
  side_t              sd1_q, sd2_q, sd3_q, sd4_q, sd5_q;
  logic signed [34:0] x1_q;
  logic signed [35:0] sp2_q;
  logic [32:0]        span3_q;
  logic [22:0]        mant2_q, mant3_q;
  logic [7:0]         sh2_q, sh3_q, sh4_q;
  logic [55:0]        prod4_q;
  logic [TB-1:0]      val5_q;

  side_t              sd1;
  logic signed [34:0] x1;
  logic signed [34:0] q2;
  logic [7:0]         size1;
  logic [4:0]         msft;
  logic [32:0]        span3;

  // Stage 1: elapsed time minus target, and the bypass decisions.
  assign x1 = $signed({3'b0, lmt0_q}) - $signed({3'b0, fmt0_q}) - $signed({3'b0, cfg_i.tt});
  always_comb begin
    sd1.nr    = cfg_i.nr;
    sd1.early = ht0_q < {15'b0, cfg_i.interval};
    sd1.bits  = bits0_q;
  end

  // Stage 2: divide by four rounding toward zero; mantissa pre-shift for small exponents.
  assign q2    = x1_q[34] ? ((x1_q + 35'sd3) >>> 2) : (x1_q >>> 2);
  assign size1 = sd1_q.bits[31:24];
  assign msft  = {2'd3 - size1[1:0], 3'b0};

  // Stage 3: clamp to the bounds.
  always_comb begin
    if (sp2_q < $signed({3'b0, cfg_i.lo})) begin
      span3 = cfg_i.lo;
    end else if (sp2_q > $signed({3'b0, cfg_i.hi})) begin
      span3 = cfg_i.hi;
    end else begin
      span3 = sp2_q[32:0];
    end
  end

  // Valid bits of the six stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[4:0], acc_i};
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (acc_i) begin
        bits0_q <= last_bits_i;
        ht0_q   <= last_height_i;
        lmt0_q  <= last_median_time_i;
        fmt0_q  <= first_median_time_i;
      end
      sd1_q   <= sd1;
      x1_q    <= x1;
      sd2_q   <= sd1_q;
      sp2_q   <= $signed({4'b0, cfg_i.tt}) + {q2[34], q2};
      mant2_q <= (size1 <= 8'd3) ? (sd1_q.bits[22:0] >> msft) : sd1_q.bits[22:0];
      sh2_q   <= (size1 > 8'd3) ? (size1 - 8'd3) : 8'd0;
      sd3_q   <= sd2_q;
      span3_q <= span3;
      mant3_q <= mant2_q;
      sh3_q   <= sh2_q;
      sd4_q   <= sd3_q;
      prod4_q <= {33'b0, mant3_q} * {23'b0, span3_q};
      sh4_q   <= sh3_q;
      sd5_q   <= sd4_q;
      // Bits shifted past the top of the target are dropped here.
      val5_q  <= TB'(prod4_q) << {sh4_q, 3'b0};
    end
  end

  assign vld_o = vld_q[5];
  assign val_o = val5_q;
  always_comb begin
    dat_o         = '0;
    dat_o.side    = sd5_q;
    dat_o.rem     = 32'd0;
    dat_o.lead_ok = 1'b0;
    dat_o.lead    = '0;
    dat_o.gt      = 1'b0;
    dat_o.lt      = 1'b0;
  end

endmodule
`default_nettype wire

FILE: design/dr_cell.sv
// One divider cell: one quotient bit, leading-one tracking and limit compare for it.
// Depends on dr_pkg for cell_t.
`default_nettype none
module dr_cell import dr_pkg::*; #(
  parameter int TB  = 256,
  parameter int POS = 255
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic [31:0]   div_i,
  input  wire logic          lim_bit_i,
  input  wire logic          vld_i,
  input  wire cell_t         dat_i,
  input  wire logic [TB-1:0] w_i,
  output logic               vld_o,
  output cell_t              dat_o,
  output logic      [TB-1:0] w_o
);

  logic          vld_q;
  cell_t         dat_q;
  logic [TB-1:0] w_q;
  logic [32:0]   t33;
  logic          qb;
  cell_t         nxt;

  // Restoring step: bring down the next dividend bit, subtract if it fits.
  assign t33 = {dat_i.rem, w_i[TB-1]};
  assign qb  = t33 >= {1'b0, div_i};

  always_comb begin
    nxt     = dat_i;
    nxt.rem = qb ? 32'(t33 - {1'b0, div_i}) : t33[31:0];
    if (qb && !dat_i.lead_ok) begin
      nxt.lead_ok = 1'b1;
      nxt.lead    = LeadW'(POS);
    end
    // Quotient bits arrive from the top, so the first difference decides.
    if (!dat_i.gt && !dat_i.lt) begin
      nxt.gt = qb && !lim_bit_i;
      nxt.lt = !qb && lim_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dat_q <= nxt;
      w_q   <= {w_i[TB-2:0], qb};
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;
  assign w_o   = w_q;

endmodule
`default_nettype wire
